>>> hw/rtl/talker_seat_pan_allocator_assert.svh
// Assertion macros used by the talker seat pan allocator back end.
`ifndef TALKER_SEAT_PAN_ALLOCATOR_ASSERT_SVH
`define TALKER_SEAT_PAN_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSPA_ASSERT_NOW(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error("tspa assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSPA_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error("tspa assertion failed");

`endif

>>> hw/rtl/tspa_pkg.sv
// Shared types, constants and the spread table for the talker seat pan allocator.
package tspa_pkg;

    localparam int SEATS_PER_REGION = 16;
    localparam int REGIONS          = 3;
    localparam int SEAT_TOTAL       = REGIONS * SEATS_PER_REGION;
    localparam int SLOT_W           = $clog2(SEATS_PER_REGION);
    localparam int SEAT_W           = $clog2(SEAT_TOTAL);

    localparam int CONN_W   = 64;
    localparam int CLIENT_W = 16;
    localparam int PAN_W    = 16;
    localparam int MAG_W    = 15;
    localparam int WIDTH_W  = 15;
    localparam int FRAC_W   = 14;
    localparam int PAN_ONE  = 16384;
    localparam int ROUND_HALF = 8192;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPERT_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_CONNECTION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_HOME     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_WHISPER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_OTHER    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_WIDTH    = 3'd5;

    localparam logic [1:0] REGION_CENTER = 2'd0;
    localparam logic [1:0] REGION_LEFT   = 2'd1;
    localparam logic [1:0] REGION_RIGHT  = 2'd2;
    localparam logic [1:0] REGION_BAD    = 2'd3;

    localparam logic [1:0] OUTCOME_SEATED    = 2'd0;
    localparam logic [1:0] OUTCOME_REMOVED   = 2'd1;
    localparam logic [1:0] OUTCOME_NOT_FOUND = 2'd2;
    localparam logic [1:0] OUTCOME_FULL      = 2'd3;

    // One classified transaction waiting for the back end.
    typedef struct packed {
        logic                start;
        logic                basic;
        logic [1:0]          region;
        logic [CONN_W-1:0]   conn;
        logic [CLIENT_W-1:0] client;
    } job_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } pan_entry_t;

    // Spread table lookup; slots past the table fall back to entry 0.
    function automatic pan_entry_t table_entry(input logic basic, input logic [1:0] region,
                                               input logic [SLOT_W-1:0] slot);
        pan_entry_t e;
        int unsigned s;
        s = int'(slot);
        e.neg = 1'b0;
        e.mag = '0;
        if (basic) begin
            if (s >= 5) s = 0;
            case (s)
                1:       begin e.neg = 1'b1; e.mag = 15'd8192;  end
                2:       begin e.neg = 1'b0; e.mag = 15'd8192;  end
                3:       begin e.neg = 1'b1; e.mag = 15'd16384; end
                4:       begin e.neg = 1'b0; e.mag = 15'd16384; end
                default: begin e.neg = 1'b0; e.mag = 15'd0;     end
            endcase
        end else begin
            if (s >= 9) s = 0;
            if (region == REGION_LEFT || region == REGION_RIGHT) begin
                e.neg = (region == REGION_LEFT);
                case (s)
                    1:       e.mag = 15'd16384;
                    2:       e.mag = 15'd8192;
                    3:       e.mag = 15'd14336;
                    4:       e.mag = 15'd10240;
                    5:       e.mag = 15'd15360;
                    6:       e.mag = 15'd13312;
                    7:       e.mag = 15'd9216;
                    8:       e.mag = 15'd11264;
                    default: e.mag = 15'd12288;
                endcase
            end else begin
                // center: odd slots lean left
                e.neg = (s[0] == 1'b1);
                case (s)
                    1, 2:    e.mag = 15'd3277;
                    3, 4:    e.mag = 15'd6554;
                    5, 6:    e.mag = 15'd1638;
                    7, 8:    e.mag = 15'd4915;
                    default: e.mag = 15'd0;
                endcase
            end
        end
        return e;
    endfunction

    function automatic logic [1:0] decode_region(input logic [1:0] code);
        return (code == REGION_BAD) ? REGION_CENTER : code;
    endfunction

endpackage

>>> hw/rtl/talker_seat_pan_allocator.sv
// Top level of the talker seat pan allocator: front end, job queue and back end.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the six
//   registers; cfg_ready is always high. Write only while no transaction is in
//   flight. s_ channel carries talk start/stop events; m_ channel returns exactly
//   one result transaction per event, in order.
// Steps, from the s_ accepting edge until m_valid rises:
//   start event: queue pop, then the seats of the region are probed (1..16),
//     one valid bit per cycle, then one multiply and one round/saturate step.
//   stop event: queue pop, then for each seat compared a seat memory read plus
//     a compare. Worst case (not found): 64 seats are compared.
// Throughput: one event at a time in the back end; the two-entry queue lets the
//   front accept further events while the back end works or waits on m_ready.
// Reset: aresetn (synchronous, low) clears all seat valid bits at once, empties
//   the queue and restores register defaults (spread_width = 1.0). No clearing
//   pass is needed. If m_ready is held low the result stays on m_, the back end
//   waits, and s_ready drops once the queue fills.
module talker_seat_pan_allocator import tspa_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_starts_talking,
    input  logic [63:0]          s_connection_id,
    input  logic [15:0]          s_client_id,
    input  logic                 s_is_whisper,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_outcome,
    output logic [1:0]           m_region_used,
    output logic [3:0]           m_slot_index,
    output logic signed [15:0]   m_pan_value
);

    // classified transaction from the front end into the queue
    logic               push_valid;
    job_t               push_job;
    logic               q_full;
    // queue head toward the back end
    logic               pop_valid;
    logic               pop_ready;
    job_t               pop_job;
    // register value used by the pan multiply
    logic [WIDTH_W-1:0] spread_width;

    tspa_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_starts_talking (s_starts_talking),
        .s_connection_id  (s_connection_id),
        .s_client_id      (s_client_id),
        .s_is_whisper     (s_is_whisper),
        .push_valid       (push_valid),
        .push_job         (push_job),
        .q_full           (q_full),
        .spread_width     (spread_width)
    );

    tspa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .q_full     (q_full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // back end owns the seat memory and the result register
    tspa_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_job       (pop_job),
        .spread_width  (spread_width),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_outcome     (m_outcome),
        .m_region_used (m_region_used),
        .m_slot_index  (m_slot_index),
        .m_pan_value   (m_pan_value)
    );

endmodule

>>> hw/rtl/tspa_front.sv
// Front end: configuration registers, input handshake and region classification.
module tspa_front import tspa_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_starts_talking,
    input  logic [CONN_W-1:0]    s_connection_id,
    input  logic [CLIENT_W-1:0]  s_client_id,
    input  logic                 s_is_whisper,
    output logic                 push_valid,
    output job_t                 push_job,
    input  logic                 q_full,
    output logic [WIDTH_W-1:0]   spread_width
);

    logic               expert_mode_reg;
    logic [CONN_W-1:0]  home_connection_reg;
    logic [1:0]         region_home_reg;
    logic [1:0]         region_whisper_reg;
    logic [1:0]         region_other_reg;
    logic [WIDTH_W-1:0] spread_width_reg;
    logic [1:0]         expected;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expert_mode_reg     <= 1'b0;
            home_connection_reg <= '0;
            region_home_reg     <= REGION_CENTER;
            region_whisper_reg  <= REGION_CENTER;
            region_other_reg    <= REGION_CENTER;
            spread_width_reg    <= WIDTH_W'(PAN_ONE);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_EXPERT_MODE:     expert_mode_reg     <= cfg_data[0];
                CFG_HOME_CONNECTION: home_connection_reg <= cfg_data[CONN_W-1:0];
                CFG_REGION_HOME:     region_home_reg     <= cfg_data[1:0];
                CFG_REGION_WHISPER:  region_whisper_reg  <= cfg_data[1:0];
                CFG_REGION_OTHER:    region_other_reg    <= cfg_data[1:0];
                CFG_SPREAD_WIDTH:    spread_width_reg    <= cfg_data[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (s_is_whisper)
            expected = decode_region(region_whisper_reg);
        else if (s_connection_id == home_connection_reg)
            expected = decode_region(region_home_reg);
        else
            expected = decode_region(region_other_reg);
    end

    assign s_ready    = !q_full;
    assign push_valid = s_valid && !q_full;

    // stop events always search the expected region first, whatever the mode
    always_comb begin
        push_job.start  = s_starts_talking;
        push_job.basic  = !expert_mode_reg;
        push_job.region = (s_starts_talking && !expert_mode_reg) ? REGION_CENTER : expected;
        push_job.conn   = s_connection_id;
        push_job.client = s_client_id;
    end

    assign spread_width = spread_width_reg;

endmodule

>>> hw/rtl/tspa_queue.sv
// Short job queue between the front and back ends.
module tspa_queue import tspa_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    input  job_t push_job,
    output logic q_full,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    job_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign q_full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = entry_reg[rd_ptr_reg];
    assign do_push   = push_valid && !q_full;
    assign do_pop    = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> hw/rtl/tspa_back.sv
// Back end: seat memory, sequential seat search, pan scaling and result register.
module tspa_back import tspa_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  job_t                pop_job,
    input  logic [WIDTH_W-1:0]  spread_width,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_outcome,
    output logic [1:0]          m_region_used,
    output logic [3:0]          m_slot_index,
    output logic signed [15:0]  m_pan_value
);

`include "talker_seat_pan_allocator_assert.svh"

    typedef enum logic [2:0] {
        ST_IDLE, ST_SEEK, ST_RD, ST_CMP, ST_MUL, ST_FIN, ST_OUT
    } state_t;

    localparam int ENTRY_W = CONN_W + CLIENT_W;

    state_t                    state_reg;
    job_t                      job_reg;
    logic [SLOT_W-1:0]         slot_reg;
    logic [1:0]                pass_reg;
    logic [SEAT_TOTAL-1:0]     valid_reg;
    logic [ENTRY_W-1:0]        seat_mem [SEAT_TOTAL];
    logic [ENTRY_W-1:0]        rd_data_reg;
    pan_entry_t                entry_reg;
    logic [MAG_W+WIDTH_W-1:0]  prod_reg;
    logic [1:0]                outcome_reg;
    logic [1:0]                region_out_reg;
    logic [3:0]                slot_out_reg;
    logic [PAN_W-1:0]          pan_reg;

    logic [1:0]                cur_region;
    logic [SEAT_W-1:0]         seat_k;
    logic                      slot_last;
    logic                      mem_we;
    logic                      hit;
    logic [MAG_W+WIDTH_W:0]    rounded;
    logic [PAN_W:0]            pan_mag;
    logic [PAN_W-1:0]          pan_sat;

    // pass 0 is the expected region, passes 1..3 walk regions 0, 1, 2
    assign cur_region = (pass_reg == 2'd0) ? job_reg.region : pass_reg - 2'd1;
    assign seat_k     = SEAT_W'(int'(cur_region) * SEATS_PER_REGION + int'(slot_reg));
    assign slot_last  = (slot_reg == SLOT_W'(SEATS_PER_REGION - 1));
    assign mem_we     = (state_reg == ST_SEEK) && !valid_reg[seat_k];
    assign hit        = valid_reg[seat_k] && (rd_data_reg == {job_reg.conn, job_reg.client});

    assign rounded = {1'b0, prod_reg} + (MAG_W+WIDTH_W+1)'(ROUND_HALF);
    assign pan_mag = rounded[MAG_W+WIDTH_W:FRAC_W];
    assign pan_sat = (pan_mag > (PAN_W+1)'(PAN_ONE)) ? PAN_W'(PAN_ONE) : pan_mag[PAN_W-1:0];

    assign pop_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (mem_we) seat_mem[seat_k] <= {job_reg.conn, job_reg.client};
        rd_data_reg <= seat_mem[seat_k];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            slot_reg  <= '0;
            pass_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop_valid) begin
                        job_reg   <= pop_job;
                        slot_reg  <= '0;
                        pass_reg  <= '0;
                        state_reg <= pop_job.start ? ST_SEEK : ST_RD;
                    end
                end
                ST_SEEK: begin
                    if (!valid_reg[seat_k]) begin
                        valid_reg[seat_k] <= 1'b1;
                        entry_reg      <= table_entry(job_reg.basic, cur_region, slot_reg);
                        outcome_reg    <= OUTCOME_SEATED;
                        region_out_reg <= cur_region;
                        slot_out_reg   <= slot_reg[3:0];
                        state_reg      <= ST_MUL;
                    end else if (slot_last) begin
                        outcome_reg    <= OUTCOME_FULL;
                        region_out_reg <= cur_region;
                        slot_out_reg   <= '0;
                        pan_reg        <= '0;
                        state_reg      <= ST_OUT;
                    end else begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                end
                ST_RD: begin
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (hit) begin
                        valid_reg[seat_k] <= 1'b0;
                        outcome_reg    <= OUTCOME_REMOVED;
                        region_out_reg <= cur_region;
                        slot_out_reg   <= slot_reg[3:0];
                        pan_reg        <= '0;
                        state_reg      <= ST_OUT;
                    end else if (slot_last) begin
                        if (pass_reg == 2'd3) begin
                            outcome_reg    <= OUTCOME_NOT_FOUND;
                            region_out_reg <= REGION_CENTER;
                            slot_out_reg   <= '0;
                            pan_reg        <= '0;
                            state_reg      <= ST_OUT;
                        end else begin
                            pass_reg  <= pass_reg + 2'd1;
                            slot_reg  <= '0;
                            state_reg <= ST_RD;
                        end
                    end else begin
                        slot_reg  <= slot_reg + 1'b1;
                        state_reg <= ST_RD;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= entry_reg.mag * spread_width;
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    pan_reg   <= entry_reg.neg ? (PAN_W'(0) - pan_sat) : pan_sat;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = (state_reg == ST_OUT);
    assign m_outcome     = outcome_reg;
    assign m_region_used = region_out_reg;
    assign m_slot_index  = slot_out_reg;
    assign m_pan_value   = pan_reg;

    `TSPA_ASSERT_NEXT(a_seat_taken, aclk, aresetn, mem_we, valid_reg[$past(seat_k)])
    `TSPA_ASSERT_NEXT(a_seat_freed, aclk, aresetn, (state_reg == ST_CMP) && hit, !valid_reg[$past(seat_k)])
    `TSPA_ASSERT_NOW(a_cmp_after_rd, aclk, aresetn, state_reg == ST_CMP, $past(state_reg) == ST_RD)
    `TSPA_ASSERT_NOW(a_not_found_zero, aclk, aresetn, m_valid && (m_outcome == OUTCOME_NOT_FOUND), (m_region_used == REGION_CENTER) && (m_slot_index == 4'd0) && (m_pan_value == 16'sd0))

endmodule
